FILE: hdl/qrpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpt_pkg
// Shared types, widths and register codes of the quaternion point transform.
// ----------------------------------------------------------------------------
package qrpt_pkg;

   localparam int ROT_W    = 16;
   localparam int COORD_W  = 32;
   localparam int COEF_W   = 34;
   localparam int NORM_W   = 33;
   localparam int PROD_W   = COEF_W + COORD_W;
   localparam int NUM_W    = PROD_W + 2;
   localparam int MAG_W    = NUM_W - 1;
   localparam int QUO_BITS = MAG_W - NORM_W;
   localparam int SUM_W    = COORD_W + 5;
   localparam int LANE_LAT = QUO_BITS + 6;
   localparam int TOTAL_LAT = LANE_LAT + 1;

   localparam logic [ROT_W-1:0] ROT_W_RESET = 16'h4000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      REG_ROT_W   = 3'd0,
      REG_ROT_X   = 3'd1,
      REG_ROT_Y   = 3'd2,
      REG_ROT_Z   = 3'd3,
      REG_TRANS_X = 3'd4,
      REG_TRANS_Y = 3'd5,
      REG_TRANS_Z = 3'd6
   } reg_type;

   // One row of the rotation matrix scaled by the squared norm.
   typedef struct packed {
      logic signed [COEF_W-1:0] c0;
      logic signed [COEF_W-1:0] c1;
      logic signed [COEF_W-1:0] c2;
   } row_type;

   // Flags and translation that ride along with the divider.
   typedef struct packed {
      logic                      neg;
      logic                      big;
      logic signed [COORD_W-1:0] trans;
   } side_type;

endpackage
`default_nettype wire

FILE: hdl/qrpt_coef.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpt_coef
// Derives the scaled rotation matrix and the squared norm from the quaternion.
// ----------------------------------------------------------------------------
module qrpt_coef (
   input  wire logic                               clock,
   input  wire logic signed [qrpt_pkg::ROT_W-1:0]  rot_w,
   input  wire logic signed [qrpt_pkg::ROT_W-1:0]  rot_x,
   input  wire logic signed [qrpt_pkg::ROT_W-1:0]  rot_y,
   input  wire logic signed [qrpt_pkg::ROT_W-1:0]  rot_z,
   output qrpt_pkg::row_type                       row_x_ff,
   output qrpt_pkg::row_type                       row_y_ff,
   output qrpt_pkg::row_type                       row_z_ff,
   output logic [qrpt_pkg::NORM_W-1:0]             norm_ff
);
   localparam int PW = 2 * qrpt_pkg::ROT_W;
   localparam int CW = qrpt_pkg::COEF_W;

   logic signed [PW-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   qrpt_pkg::row_type row_x_in, row_y_in, row_z_in;
   logic [qrpt_pkg::NORM_W-1:0] norm_in;

   always_ff @(posedge clock) begin
      ww_ff <= rot_w * rot_w;
      xx_ff <= rot_x * rot_x;
      yy_ff <= rot_y * rot_y;
      zz_ff <= rot_z * rot_z;
      xy_ff <= rot_x * rot_y;
      wz_ff <= rot_w * rot_z;
      xz_ff <= rot_x * rot_z;
      wy_ff <= rot_w * rot_y;
      yz_ff <= rot_y * rot_z;
      wx_ff <= rot_w * rot_x;
   end

   always_comb begin
      row_x_in.c0 = CW'(ww_ff) + CW'(xx_ff) - CW'(yy_ff) - CW'(zz_ff);
      row_x_in.c1 = (CW'(xy_ff) - CW'(wz_ff)) <<< 1;
      row_x_in.c2 = (CW'(xz_ff) + CW'(wy_ff)) <<< 1;
      row_y_in.c0 = (CW'(xy_ff) + CW'(wz_ff)) <<< 1;
      row_y_in.c1 = CW'(ww_ff) - CW'(xx_ff) + CW'(yy_ff) - CW'(zz_ff);
      row_y_in.c2 = (CW'(yz_ff) - CW'(wx_ff)) <<< 1;
      row_z_in.c0 = (CW'(xz_ff) - CW'(wy_ff)) <<< 1;
      row_z_in.c1 = (CW'(yz_ff) + CW'(wx_ff)) <<< 1;
      row_z_in.c2 = CW'(ww_ff) - CW'(xx_ff) - CW'(yy_ff) + CW'(zz_ff);
      // Squares are never negative, so their low bits add as unsigned values.
      norm_in = {1'b0, ww_ff[PW-1:0]} + {1'b0, xx_ff[PW-1:0]}
              + {1'b0, yy_ff[PW-1:0]} + {1'b0, zz_ff[PW-1:0]};
   end

   always_ff @(posedge clock) begin
      row_x_ff <= row_x_in;
      row_y_ff <= row_y_in;
      row_z_ff <= row_z_in;
      norm_ff  <= norm_in;
   end

endmodule
`default_nettype wire

FILE: hdl/qrpt_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpt_div_stage
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qrpt_div_stage (
   input  wire logic                                 clock,
   input  wire logic [qrpt_pkg::NORM_W-1:0]          norm,
   input  wire logic [qrpt_pkg::NORM_W-1:0]          rem_q,
   input  wire logic [qrpt_pkg::QUO_BITS-1:0]        word_q,
   input  wire qrpt_pkg::side_type                   side_q,
   output logic [qrpt_pkg::NORM_W-1:0]               rem_ff,
   output logic [qrpt_pkg::QUO_BITS-1:0]             word_ff,
   output qrpt_pkg::side_type                        side_ff
);
   localparam int NW = qrpt_pkg::NORM_W;
   localparam int QB = qrpt_pkg::QUO_BITS;

   logic [NW:0]   trial;
   logic [NW:0]   diff;
   logic          ge;
   logic [NW-1:0] rem_in;
   logic [QB-1:0] word_in;

   // The word holds the numerator bits still to bring down at its top and the
   // quotient bits already found at its bottom.
   always_comb begin
      trial   = {rem_q, word_q[QB-1]};
      diff    = trial - {1'b0, norm};
      ge      = trial >= {1'b0, norm};
      rem_in  = ge ? diff[NW-1:0] : trial[NW-1:0];
      word_in = {word_q[QB-2:0], ge};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      word_ff <= word_in;
      side_ff <= side_q;
   end

endmodule
`default_nettype wire

FILE: hdl/qrpt_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpt_lane
// One output coordinate: dot product, divide by the norm, round, translate
// and saturate.
// ----------------------------------------------------------------------------
module qrpt_lane (
   input  wire logic                                clock,
   input  wire qrpt_pkg::row_type                   row,
   input  wire logic [qrpt_pkg::NORM_W-1:0]         norm,
   input  wire logic signed [qrpt_pkg::COORD_W-1:0] p0,
   input  wire logic signed [qrpt_pkg::COORD_W-1:0] p1,
   input  wire logic signed [qrpt_pkg::COORD_W-1:0] p2,
   input  wire logic signed [qrpt_pkg::COORD_W-1:0] trans,
   output logic signed [qrpt_pkg::COORD_W-1:0]      out_ff,
   output logic                                     sat_ff
);
   localparam int CRW = qrpt_pkg::COORD_W;
   localparam int PRW = qrpt_pkg::PROD_W;
   localparam int NUW = qrpt_pkg::NUM_W;
   localparam int MGW = qrpt_pkg::MAG_W;
   localparam int NW  = qrpt_pkg::NORM_W;
   localparam int QB  = qrpt_pkg::QUO_BITS;
   localparam int SW  = qrpt_pkg::SUM_W;

   // Products.
   logic signed [PRW-1:0] pr0_ff, pr1_ff, pr2_ff;
   logic signed [CRW-1:0] t_p_ff, t_s_ff, t_m_ff;
   // Sum.
   logic signed [NUW-1:0] sum_ff;
   // Magnitude.
   logic [MGW-1:0] mag_ff, mag_in;
   logic           neg_ff;
   // Divider entry.
   logic [NW-1:0]      rem0_ff;
   logic [QB-1:0]      word0_ff;
   qrpt_pkg::side_type side0_ff, side0_in;
   // Divider chain.
   logic [NW-1:0]      rem_d   [QB+1];
   logic [QB-1:0]      word_d  [QB+1];
   qrpt_pkg::side_type side_d  [QB+1];
   // Round.
   logic [NW:0]               rnd_cmp;
   logic [QB:0]               q_rnd;
   logic signed [QB+1:0]      v_ff, v_in;
   qrpt_pkg::side_type        side_r_ff;
   // Final.
   logic signed [SW-1:0]      tot;
   logic signed [CRW-1:0]     out_in;
   logic                      sat_in;

   always_ff @(posedge clock) begin
      pr0_ff <= row.c0 * p0;
      pr1_ff <= row.c1 * p1;
      pr2_ff <= row.c2 * p2;
      t_p_ff <= trans;
   end

   always_ff @(posedge clock) begin
      sum_ff <= NUW'(pr0_ff) + NUW'(pr1_ff) + NUW'(pr2_ff);
      t_s_ff <= t_p_ff;
   end

   assign mag_in = sum_ff[NUW-1] ? MGW'(-sum_ff) : MGW'(sum_ff);

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= sum_ff[NUW-1];
      t_m_ff <= t_s_ff;
   end

   // A quotient at or above 2^QUO_BITS saturates whatever the translation.
   always_comb begin
      side0_in.neg   = neg_ff;
      side0_in.big   = mag_ff >= {norm, {QB{1'b0}}};
      side0_in.trans = t_m_ff;
   end

   always_ff @(posedge clock) begin
      rem0_ff  <= mag_ff[MGW-1:QB];
      word0_ff <= mag_ff[QB-1:0];
      side0_ff <= side0_in;
   end

   assign rem_d[0]  = rem0_ff;
   assign word_d[0] = word0_ff;
   assign side_d[0] = side0_ff;

   for (genvar g = 0; g < QB; g++) begin : g_div
      qrpt_div_stage u_stage (
         .clock   (clock),
         .norm    (norm),
         .rem_q   (rem_d[g]),
         .word_q  (word_d[g]),
         .side_q  (side_d[g]),
         .rem_ff  (rem_d[g+1]),
         .word_ff (word_d[g+1]),
         .side_ff (side_d[g+1])
      );
   end

   // Round to nearest with ties away from zero, then restore the sign.
   always_comb begin
      rnd_cmp = {rem_d[QB], 1'b0};
      q_rnd   = {1'b0, word_d[QB]} + (QB+1)'(rnd_cmp >= {1'b0, norm});
      v_in    = side_d[QB].neg ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      side_r_ff <= side_d[QB];
   end

   always_comb begin
      tot = SW'(v_ff) + SW'(side_r_ff.trans);
      if (side_r_ff.big) begin
         out_in = side_r_ff.neg ? qrpt_pkg::COORD_MIN : qrpt_pkg::COORD_MAX;
         sat_in = 1'b1;
      end else if (tot > SW'(qrpt_pkg::COORD_MAX)) begin
         out_in = qrpt_pkg::COORD_MAX;
         sat_in = 1'b1;
      end else if (tot < SW'(qrpt_pkg::COORD_MIN)) begin
         out_in = qrpt_pkg::COORD_MIN;
         sat_in = 1'b1;
      end else begin
         out_in = tot[CRW-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sat_ff <= sat_in;
   end

endmodule
`default_nettype wire

FILE: hdl/quaternion_rigid_point_transform_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_rigid_point_transform_top
// Rotates a Q16.16 point or direction by q*(0,p)*q^-1 and adds the translation
// to points, with saturation and a flag for the all-zero quaternion.
// ----------------------------------------------------------------------------
// Results: a result is strobed on rsp_valid once its item has passed the entry
// stage and the lanes, most of whose stages form the 34 stage restoring divider.
// Throughput: one item per clock cycle while busy is low; busy is high only in
// the cycle after a register write, while the derived matrix settles.
// Reset: synchronous and active high; it empties the pipeline and loads the
// identity rotation (rot_w = 1.0) with zero translation.
// ----------------------------------------------------------------------------
module quaternion_rigid_point_transform_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Item channel.
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [31:0] req_in_x,
   input  wire logic [31:0] req_in_y,
   input  wire logic [31:0] req_in_z,
   // Result channel.
   output logic             rsp_valid,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic [31:0]      rsp_out_z,
   output logic             rsp_saturated,
   output logic             rsp_degenerate,
   // Register port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int RW  = qrpt_pkg::ROT_W;
   localparam int CRW = qrpt_pkg::COORD_W;
   localparam int LAT = qrpt_pkg::LANE_LAT;

   // ------------------------------------------------------------------------
   // Register file. Writes land on the access phase of a transfer; indexes
   // past the translation registers are dropped.
   // ------------------------------------------------------------------------
   logic signed [RW-1:0]  rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   logic signed [CRW-1:0] trans_x_ff, trans_y_ff, trans_z_ff;
   logic                  csr_wr;
   logic                  cfg_wr_ff;
   qrpt_pkg::reg_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = qrpt_pkg::reg_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff   <= qrpt_pkg::ROT_W_RESET;
         rot_x_ff   <= '0;
         rot_y_ff   <= '0;
         rot_z_ff   <= '0;
         trans_x_ff <= '0;
         trans_y_ff <= '0;
         trans_z_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            qrpt_pkg::REG_ROT_W:   rot_w_ff   <= csr_pwdata[RW-1:0];
            qrpt_pkg::REG_ROT_X:   rot_x_ff   <= csr_pwdata[RW-1:0];
            qrpt_pkg::REG_ROT_Y:   rot_y_ff   <= csr_pwdata[RW-1:0];
            qrpt_pkg::REG_ROT_Z:   rot_z_ff   <= csr_pwdata[RW-1:0];
            qrpt_pkg::REG_TRANS_X: trans_x_ff <= csr_pwdata;
            qrpt_pkg::REG_TRANS_Y: trans_y_ff <= csr_pwdata;
            qrpt_pkg::REG_TRANS_Z: trans_z_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         qrpt_pkg::REG_ROT_W:   csr_prdata = {16'h0, rot_w_ff};
         qrpt_pkg::REG_ROT_X:   csr_prdata = {16'h0, rot_x_ff};
         qrpt_pkg::REG_ROT_Y:   csr_prdata = {16'h0, rot_y_ff};
         qrpt_pkg::REG_ROT_Z:   csr_prdata = {16'h0, rot_z_ff};
         qrpt_pkg::REG_TRANS_X: csr_prdata = trans_x_ff;
         qrpt_pkg::REG_TRANS_Y: csr_prdata = trans_y_ff;
         qrpt_pkg::REG_TRANS_Z: csr_prdata = trans_z_ff;
         default:               csr_prdata = '0;
      endcase
   end

   // The matrix is two register stages behind the quaternion, and an item reads
   // it in the cycle after it enters, so busy holds off items after each write.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_wr_ff <= 1'b0;
      end else begin
         cfg_wr_ff <= csr_wr;
      end
   end

   assign busy = cfg_wr_ff;

   // ------------------------------------------------------------------------
   // Scaled rotation matrix and squared norm.
   // ------------------------------------------------------------------------
   qrpt_pkg::row_type         row_x, row_y, row_z;
   logic [qrpt_pkg::NORM_W-1:0] norm;

   qrpt_coef u_coef (
      .clock    (clock),
      .rot_w    (rot_w_ff),
      .rot_x    (rot_x_ff),
      .rot_y    (rot_y_ff),
      .rot_z    (rot_z_ff),
      .row_x_ff (row_x),
      .row_y_ff (row_y),
      .row_z_ff (row_z),
      .norm_ff  (norm)
   );

   // ------------------------------------------------------------------------
   // Entry stage: capture the item and pick the translation. Directions take
   // a zero translation so that every lane runs the same datapath.
   // ------------------------------------------------------------------------
   logic                  accept;
   logic                  s0_vld_ff;
   logic signed [CRW-1:0] s0_px_ff, s0_py_ff, s0_pz_ff;
   logic signed [CRW-1:0] s0_tx_ff, s0_ty_ff, s0_tz_ff;
   logic                  point;

   assign accept = start & ~busy;
   assign point  = ~req_operation;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_px_ff <= req_in_x;
      s0_py_ff <= req_in_y;
      s0_pz_ff <= req_in_z;
      s0_tx_ff <= point ? trans_x_ff : '0;
      s0_ty_ff <= point ? trans_y_ff : '0;
      s0_tz_ff <= point ? trans_z_ff : '0;
   end

   // ------------------------------------------------------------------------
   // Three coordinate lanes, each a fixed-length pipeline. The valid bits
   // run alongside; nothing stalls because results cannot be refused.
   // ------------------------------------------------------------------------
   logic signed [CRW-1:0] lx_out, ly_out, lz_out;
   logic                  lx_sat, ly_sat, lz_sat;
   logic [LAT-1:0]        vld_ff;

   qrpt_lane u_lane_x (
      .clock (clock), .row (row_x), .norm (norm),
      .p0 (s0_px_ff), .p1 (s0_py_ff), .p2 (s0_pz_ff), .trans (s0_tx_ff),
      .out_ff (lx_out), .sat_ff (lx_sat)
   );

   qrpt_lane u_lane_y (
      .clock (clock), .row (row_y), .norm (norm),
      .p0 (s0_px_ff), .p1 (s0_py_ff), .p2 (s0_pz_ff), .trans (s0_ty_ff),
      .out_ff (ly_out), .sat_ff (ly_sat)
   );

   qrpt_lane u_lane_z (
      .clock (clock), .row (row_z), .norm (norm),
      .p0 (s0_px_ff), .p1 (s0_py_ff), .p2 (s0_pz_ff), .trans (s0_tz_ff),
      .out_ff (lz_out), .sat_ff (lz_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], s0_vld_ff};
      end
   end

   // ------------------------------------------------------------------------
   // Result. A zero norm means an all-zero quaternion; the lanes then divide
   // by zero, so their values are replaced by zero here.
   // ------------------------------------------------------------------------
   logic degen;

   assign degen          = (norm == '0);
   assign rsp_valid      = vld_ff[LAT-1];
   assign rsp_degenerate = degen;
   assign rsp_out_x      = degen ? '0 : lx_out;
   assign rsp_out_y      = degen ? '0 : ly_out;
   assign rsp_out_z      = degen ? '0 : lz_out;
   assign rsp_saturated  = ~degen & (lx_sat | ly_sat | lz_sat);

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // Every result strobe traces back to exactly one transfer taken outside
   // of reset.
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, qrpt_pkg::TOTAL_LAT))
      else $error("result strobe without a matching transfer");

   // With the identity rotation the x coordinate of a direction passes through unchanged and unsaturated.
   a_identity_dir : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rot_w_ff == qrpt_pkg::ROT_W_RESET && rot_x_ff == '0 &&
       rot_y_ff == '0 && rot_z_ff == '0 &&
       $past(req_operation, qrpt_pkg::TOTAL_LAT))
      |-> (rsp_out_x == $past(req_in_x, qrpt_pkg::TOTAL_LAT) && !rsp_saturated))
      else $error("identity rotation changed a direction");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quaternion rigid point transform. Points and
// directions are sent with random gaps under a series of rotation and
// translation settings. Every result is compared with an independent
// fixed-point prediction of the sandwich product, translation and saturation.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 50;

   // One predicted transfer on the result channel.
   typedef struct packed {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic        saturated;
      logic        degenerate;
   } point_result_type;

   // Keeps its own copy of the registers, predicts each accepted item and
   // checks the results in order.
   class transform_scoreboard;
      logic signed [15:0] quat[4];
      logic signed [31:0] trans[3];
      point_result_type   pending[$];
      int                 errors;

      function new();
         quat = '{16'sh4000, 16'sd0, 16'sd0, 16'sd0};
         trans = '{32'sd0, 32'sd0, 32'sd0};
         errors = 0;
      endfunction

      function void set_reg(qrpt_pkg::reg_type idx, logic [31:0] value);
         if (idx <= qrpt_pkg::REG_ROT_Z)
            quat[idx] = value[15:0];
         else
            trans[idx - qrpt_pkg::REG_TRANS_X] = value;
      endfunction

      // Predicts the result of one accepted item and queues it.
      function void note_input(logic op, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
         longint              w, x, y, z, norm;
         longint              m[3][3];
         logic signed [127:0] coord[3];
         logic signed [127:0] num, coef, v, shift;
         logic [127:0]        amag, quo, rem, den;
         logic [31:0]         outs[3];
         logic                sat, neg, big;
         point_result_type    e;
         w = quat[0];
         x = quat[1];
         y = quat[2];
         z = quat[3];
         coord[0] = $signed(px);
         coord[1] = $signed(py);
         coord[2] = $signed(pz);
         norm = w * w + x * x + y * y + z * z;
         e = '0;
         if (norm == 0) begin
            // An all-zero quaternion forces zero outputs and no translation.
            e.degenerate = 1'b1;
            pending.push_back(e);
            return;
         end
         m[0][0] = w * w + x * x - y * y - z * z;
         m[0][1] = 2 * (x * y - w * z);
         m[0][2] = 2 * (x * z + w * y);
         m[1][0] = 2 * (x * y + w * z);
         m[1][1] = w * w - x * x + y * y - z * z;
         m[1][2] = 2 * (y * z - w * x);
         m[2][0] = 2 * (x * z - w * y);
         m[2][1] = 2 * (y * z + w * x);
         m[2][2] = w * w - x * x - y * y + z * z;
         den = norm;
         sat = 1'b0;
         for (int i = 0; i < 3; i++) begin
            num = '0;
            for (int j = 0; j < 3; j++) begin
               coef = m[i][j];
               num = num + coef * coord[j];
            end
            neg = num < 0;
            amag = neg ? -num : num;
            quo = amag / den;
            rem = amag % den;
            big = quo >= (128'd1 << 62);
            if (big) begin
               // A quotient this large clamps whatever the translation is.
               sat = 1'b1;
               outs[i] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               if (2 * rem >= den)
                  quo = quo + 1;
               v = neg ? -$signed(quo) : $signed(quo);
               shift = (op == 1'b0) ? trans[i] : 128'sd0;
               v = v + shift;
               if (v > 128'sd2147483647) begin
                  sat = 1'b1;
                  v = 128'sd2147483647;
               end else if (v < -128'sd2147483648) begin
                  sat = 1'b1;
                  v = -128'sd2147483648;
               end
               outs[i] = v[31:0];
            end
         end
         e.out_x = outs[0];
         e.out_y = outs[1];
         e.out_z = outs[2];
         e.saturated = sat;
         pending.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(point_result_type got);
         point_result_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = pending.pop_front();
         compare_field("out_x", want.out_x, got.out_x);
         compare_field("out_y", want.out_y, got.out_y);
         compare_field("out_z", want.out_z, got.out_z);
         compare_field("saturated", want.saturated, got.saturated);
         compare_field("degenerate", want.degenerate, got.degenerate);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [31:0] req_in_x;
   logic [31:0] req_in_y;
   logic [31:0] req_in_z;
   logic        rsp_valid;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [31:0] rsp_out_z;
   logic        rsp_saturated;
   logic        rsp_degenerate;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   transform_scoreboard sb;
   int                  cycle_count;
   // When set, the sender runs without any gaps.
   bit                  burst_mode;

   quaternion_rigid_point_transform_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_in_x(req_in_x),
      .req_in_y(req_in_y),
      .req_in_z(req_in_z),
      .rsp_valid(rsp_valid),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_saturated(rsp_saturated),
      .rsp_degenerate(rsp_degenerate),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog counts every cycle; a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Results cannot be held off, so every strobed cycle is one transfer. The
   // outputs are read right after the edge, before the block updates them.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated, rsp_degenerate});
   end

   // Mostly back-to-back, sometimes a short pause and now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (burst_mode || roll < 65)
         return 0;
      if (roll < 95)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Offers one item and holds it until the block takes it. On a zero gap
   // start stays high so that the next item follows in the very next cycle.
   task automatic send_item(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      start <= 1'b1;
      req_operation <= op;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      do
         @(posedge clock);
      while (busy);
      sb.note_input(op, x, y, z);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops the sender and waits until every predicted result has arrived.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Setup cycle, then the access cycle, then idle; pready is always high.
   task automatic csr_write(qrpt_pkg::reg_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic set_transform(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
      csr_write(qrpt_pkg::REG_ROT_W, {16'h0, w});
      csr_write(qrpt_pkg::REG_ROT_X, {16'h0, x});
      csr_write(qrpt_pkg::REG_ROT_Y, {16'h0, y});
      csr_write(qrpt_pkg::REG_ROT_Z, {16'h0, z});
      csr_write(qrpt_pkg::REG_TRANS_X, tx);
      csr_write(qrpt_pkg::REG_TRANS_Y, ty);
      csr_write(qrpt_pkg::REG_TRANS_Z, tz);
   endtask

   // Small coordinates rarely clamp; full-range ones exercise saturation.
   function automatic logic [31:0] random_coord();
      int roll;
      roll = $urandom_range(9);
      if (roll < 5)
         return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      if (roll == 5)
         return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(15)
                                  : 32'h8000_0000 + $urandom_range(15);
      return $urandom;
   endfunction

   function automatic logic [15:0] random_quat();
      int roll;
      roll = $urandom_range(9);
      if (roll < 4)
         return 16'($urandom_range(16'h8000) - 16'h4000);
      if (roll == 4)
         return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      if (roll == 5)
         return 16'($urandom_range(2) - 1);
      return 16'($urandom);
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++)
         send_item(1'($urandom_range(1)), random_coord(), random_coord(), random_coord());
   endtask

   initial begin
      logic [31:0] corner[6];
      sb = new();
      cycle_count = 0;
      burst_mode = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = 1'b0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset identity: field extremes, both operations.
      corner = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
      for (int i = 0; i < 6; i++)
         send_item(1'(i % 2), corner[i], corner[(i + 3) % 6], corner[(i + 4) % 6]);

      // Full translation pushes points past the limit, while directions skip it.
      drain();
      set_transform(16'h4000, 16'h0, 16'h0, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
      send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_item(1'b0, 32'h0, 32'h0, 32'hFFFF_0000);

      // A tiny quaternion divides by a small norm; a large point still clamps.
      drain();
      set_transform(16'h0001, 16'h0, 16'h0, 16'h0001, 32'h0, 32'h0, 32'h7FFF_FFFF);
      send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(1'b0, 32'h1, 32'h0, 32'h0);

      // Most negative components give the largest norm.
      drain();
      set_transform(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000);
      send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(1'b0, 32'hFFFF_FFFF, 32'h1, 32'h3);

      // The all-zero quaternion yields zeros and the degenerate flag.
      drain();
      set_transform(16'h0, 16'h0, 16'h0, 16'h0, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
      send_item(1'b1, 32'h1, 32'h2, 32'h3);
      random_items(20);

      // Random phases, each under its own setting; some run without gaps.
      for (int phase = 0; phase < 14; phase++) begin
         drain();
         burst_mode = (phase % 4) == 3;
         case (phase % 5)
            0: set_transform(16'h2D41, 16'h2D41, 16'h0, 16'h0, $urandom, $urandom, $urandom);
            1: set_transform(16'h4000, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
            default: set_transform(random_quat(), random_quat(), random_quat(), random_quat(),
                                   $urandom_range(1) ? $urandom : random_coord(),
                                   random_coord(), $urandom);
         endcase
         random_items(122);
      end
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/qrpt_pkg.sv
hdl/qrpt_coef.sv
hdl/qrpt_div_stage.sv
hdl/qrpt_lane.sv
hdl/quaternion_rigid_point_transform_top.sv
tb/testbench.sv
